// ===== design/scfp_pkg.sv =====
// scfp_pkg: shared types and constants of the serial command frame parser
// used by serial_command_frame_parser_top and its checker, no dependencies
package scfp_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h3C;  // '<'
    localparam logic [7:0] CH_TEXT   = 8'h40;  // '@'
    localparam logic [7:0] CH_BINARY = 8'h21;  // '!'
    localparam logic [7:0] CH_CLOSE  = 8'h3E;  // '>'
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_WS_LO  = 8'h09;
    localparam logic [7:0] CH_WS_HI  = 8'h0D;

    localparam logic [7:0] ECHO_CODE_RST   = 8'd69;
    localparam logic [7:0] STATUS_CODE_RST = 8'd83;
    localparam logic [7:0] MOTOR_CODE_RST  = 8'd77;

    localparam logic [2:0]  TOKEN_ENDED = 3'd7;
    localparam logic [2:0]  TOKEN_LAST  = 3'd6;
    localparam logic [15:0] TOKEN_SAT   = 16'd32768;
    localparam logic [15:0] TOKEN_MAX   = 16'd32767;

    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        KIND_ECHO    = 3'd0,
        KIND_STATUS  = 3'd1,
        KIND_MOTOR   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_BINARY  = 3'd4
    } t_frame_kind;

    typedef enum logic [1:0] {
        CFG_ECHO_CODE   = 2'd0,
        CFG_STATUS_CODE = 2'd1,
        CFG_MOTOR_CODE  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic in_tok;
        logic neg;
        logic stop;
        logic seen;
    } t_tok_flags;

endpackage

// ===== design/serial_command_frame_parser_top.sv =====
// serial_command_frame_parser_top: byte stream frame parser with motor command decode
// depends on scfp_pkg
//
// Takes one received byte per transfer and can accept a byte in every cycle; each byte
// is handled in the cycle it is accepted and a completed frame shows up on the output
// register the cycle after its closing byte. A new byte is taken while a result waits,
// as long as the output register is free or is being read in the same cycle. Frames are
// '<', '@' (text) or '!' (binary), a space and the body; text frames end at '>', binary
// frames when the position equals the first body byte's value. Bytes are counted up to
// BUFFER_SIZE; a longer frame is dropped. Output tdata, from bit 0: frame_kind[2:0],
// command_code[10:3], frame_length[17:11], speed_right[33:18], speed_left[49:34],
// auto_flag[65:50], zeros above. Command codes, cfg index 0 echo, 1 status, 2 motor,
// are written by the user only while the parser is idle; the block does not check.
module serial_command_frame_parser_top
    import scfp_pkg::*;
#(
    parameter int BUFFER_SIZE = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // rx_byte[7:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // kind, code, length, right, left, auto
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    localparam int PW = $clog2(BUFFER_SIZE + 1);

    logic [7:0]        r_echo_code, r_status_code, r_motor_code;
    logic [PW-1:0]     r_pos, n_pos;
    logic              r_binary, n_binary;
    logic [7:0]        r_first, n_first;
    logic [2:0]        r_tok_idx, n_tok_idx;
    logic [15:0]       r_tok_val, n_tok_val;
    t_tok_flags        r_tok_flags, n_tok_flags;
    logic signed [15:0] r_pend [3];
    logic signed [15:0] n_pend [3];
    logic signed [15:0] fin_pend [3];
    logic [2:0]        r_present, n_present;
    logic signed [15:0] r_right, n_right, r_left, n_left, r_auto, n_auto;
    logic              r_m_tvalid, n_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic              accept;
    logic [7:0]        b;
    logic              is_digit, is_ws;
    logic signed [15:0] fin_val;
    logic signed [15:0] spd_right, spd_left;
    logic              emit;
    t_frame_kind       kind;
    logic [7:0]        code;

    function automatic logic [15:0] accumulate(input logic [15:0] v, input logic [3:0] d);
        logic [19:0] t;
        t = 20'(v) * 20'd10 + 20'(d);
        return (t > 20'(TOKEN_SAT)) ? TOKEN_SAT : t[15:0];
    endfunction

    // trunc(v * 510 / 1024) - 255, rounding towards zero
    function automatic logic signed [15:0] to_speed(input logic signed [15:0] v);
        logic signed [25:0] p;
        logic signed [25:0] q;
        p = 26'(v) * 26'sd510;
        q = p[25] ? ((p + 26'sd1023) >>> 10) : (p >>> 10);
        return 16'(q - 26'sd255);
    endfunction

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_cfg_ready = 1'b1;

    assign b        = i_s_tdata;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws    = (b >= CH_WS_LO) && (b <= CH_WS_HI);

    // value the open token would leave in its slot
    always_comb begin
        if (r_tok_flags.neg) begin
            fin_val = 16'(-$signed({1'b0, r_tok_val}));
        end else begin
            fin_val = (r_tok_val > TOKEN_MAX) ? TOKEN_MAX : r_tok_val;
        end
        for (int k = 0; k < 3; k++) begin
            fin_pend[k] = (r_tok_flags.in_tok && r_tok_idx == 3'(k + 3)) ? fin_val
                                                                          : r_pend[k];
        end
    end

    assign spd_right = to_speed(fin_pend[0]);
    assign spd_left  = to_speed(fin_pend[1]);

    always_comb begin
        n_pos       = r_pos;
        n_binary    = r_binary;
        n_first     = r_first;
        n_tok_idx   = r_tok_idx;
        n_tok_val   = r_tok_val;
        n_tok_flags = r_tok_flags;
        n_pend      = r_pend;
        n_present   = r_present;
        n_right     = r_right;
        n_left      = r_left;
        n_auto      = r_auto;
        emit        = 1'b0;
        kind        = KIND_UNKNOWN;
        code        = r_first;

        if (accept) begin
            if (r_pos == PW'(0)) begin
                if (b == CH_OPEN) begin
                    n_pos = PW'(1);
                end
            end else if (r_pos == PW'(1)) begin
                if (b == CH_TEXT || b == CH_BINARY) begin
                    n_binary = (b == CH_BINARY);
                    n_pos    = PW'(2);
                end else begin
                    n_pos = PW'(0);
                end
            end else if (r_pos == PW'(2)) begin
                n_pos = (b == CH_SPACE) ? PW'(3) : PW'(0);
            end else if (!r_binary && b == CH_CLOSE) begin
                emit  = 1'b1;
                n_pos = PW'(0);
                if (r_pos == PW'(3)) begin
                    kind = KIND_UNKNOWN;
                    code = 8'd0;
                end else if (r_first == r_echo_code) begin
                    kind = KIND_ECHO;
                end else if (r_first == r_status_code) begin
                    kind = KIND_STATUS;
                end else if (r_first == r_motor_code) begin
                    kind = KIND_MOTOR;
                    if (r_present[0]) n_right = spd_right;
                    if (r_present[1]) n_left  = spd_left;
                    if (r_present[2]) n_auto  = fin_pend[2];
                end else begin
                    kind = KIND_UNKNOWN;
                end
            end else if (r_binary && r_pos >= PW'(4) && r_first == 8'(r_pos)) begin
                emit  = 1'b1;
                kind  = KIND_BINARY;
                n_pos = PW'(0);
            end else if (r_pos >= PW'(BUFFER_SIZE)) begin
                n_pos = (b == CH_OPEN) ? PW'(1) : PW'(0);
            end else begin
                if (r_pos == PW'(3)) begin
                    n_first = b;
                end
                n_pos = r_pos + PW'(1);
                if (!r_binary && r_tok_idx != TOKEN_ENDED) begin
                    if (b == CH_NUL || b == CH_SPACE) begin
                        n_pend      = fin_pend;
                        n_tok_flags = '0;
                        if (b == CH_NUL) begin
                            n_tok_idx = TOKEN_ENDED;
                        end
                    end else begin
                        if (!r_tok_flags.in_tok) begin
                            n_tok_flags        = '0;
                            n_tok_flags.in_tok = 1'b1;
                            n_tok_val          = 16'd0;
                            if (r_tok_idx < TOKEN_LAST) begin
                                n_tok_idx = r_tok_idx + 3'd1;
                            end
                            case (n_tok_idx)
                                3'd3:    n_present[0] = 1'b1;
                                3'd4:    n_present[1] = 1'b1;
                                3'd5:    n_present[2] = 1'b1;
                                default: ;
                            endcase
                        end
                        if (!n_tok_flags.stop) begin
                            if (!n_tok_flags.seen) begin
                                if (is_ws) begin
                                    n_tok_flags.seen = 1'b0;
                                end else if (b == CH_PLUS) begin
                                    n_tok_flags.seen = 1'b1;
                                end else if (b == CH_MINUS) begin
                                    n_tok_flags.seen = 1'b1;
                                    n_tok_flags.neg  = 1'b1;
                                end else if (is_digit) begin
                                    n_tok_flags.seen = 1'b1;
                                    n_tok_val = accumulate(n_tok_val, b[3:0]);
                                end else begin
                                    n_tok_flags.stop = 1'b1;
                                end
                            end else if (is_digit) begin
                                n_tok_val = accumulate(n_tok_val, b[3:0]);
                            end else begin
                                n_tok_flags.stop = 1'b1;
                            end
                        end
                    end
                end
            end

            // start of a new frame clears the per-frame state
            if (n_pos == PW'(1)) begin
                n_binary    = 1'b0;
                n_first     = 8'd0;
                n_tok_idx   = 3'd1;
                n_tok_val   = 16'd0;
                n_tok_flags = '0;
                n_pend      = '{default: '0};
                n_present   = 3'd0;
            end
        end
    end

    always_comb begin
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        if (emit) begin
            n_m_tvalid = 1'b1;
            n_m_tdata  = {6'd0, n_auto, n_left, n_right, 7'(r_pos), code, kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_code   <= ECHO_CODE_RST;
            r_status_code <= STATUS_CODE_RST;
            r_motor_code  <= MOTOR_CODE_RST;
            r_pos         <= '0;
            r_binary      <= 1'b0;
            r_first       <= 8'd0;
            r_tok_idx     <= 3'd0;
            r_tok_val     <= 16'd0;
            r_tok_flags   <= '0;
            r_pend        <= '{default: '0};
            r_present     <= 3'd0;
            r_right       <= '0;
            r_left        <= '0;
            r_auto        <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ECHO_CODE:   r_echo_code   <= i_cfg_data;
                    CFG_STATUS_CODE: r_status_code <= i_cfg_data;
                    CFG_MOTOR_CODE:  r_motor_code  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos       <= n_pos;
            r_binary    <= n_binary;
            r_first     <= n_first;
            r_tok_idx   <= n_tok_idx;
            r_tok_val   <= n_tok_val;
            r_tok_flags <= n_tok_flags;
            r_pend      <= n_pend;
            r_present   <= n_present;
            r_right     <= n_right;
            r_left      <= n_left;
            r_auto      <= n_auto;
            r_m_tvalid  <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
    end

endmodule

// ===== design/scfp_checker.sv =====
// scfp_checker: port-level checks of serial_command_frame_parser_top, bound to it below
// depends on scfp_pkg
module scfp_checker
    import scfp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata    // kind, code, length, right, left, auto
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a new result needs an input transfer in the cycle before
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("result without input transfer");

    // input is taken whenever the output register is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // frame kind stays within its codes
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= KIND_BINARY))
        else $error("bad frame kind");

endmodule

bind serial_command_frame_parser_top scfp_checker u_scfp_checker (.*);

// ===== sim/serial_command_frame_parser_top_tb.sv =====
// serial_command_frame_parser_top_tb: self-checking bench for the serial command frame parser
// drives byte streams and command code writes, predicts every frame result in a scoreboard
// depends on scfp_pkg and serial_command_frame_parser_top
module serial_command_frame_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scfp_pkg::*;

    localparam int          BUF_BYTES   = 64;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          IDLE_MAX    = 11;
    localparam int          TAIL_CYCLES = 8;
    localparam int          PHASE_BYTES = 20;
    localparam int          SPEED_NUM   = 510;
    localparam int          SPEED_DEN   = 1024;
    localparam int          SPEED_OFS   = 255;
    localparam logic [7:0]  FILL_BYTE   = 8'h78;

    // mirrors the output tdata layout, last member in the lowest bits
    typedef struct packed {
        logic [5:0]         zero_pad;
        logic signed [15:0] auto_mode;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic [6:0]         frame_length;
        logic [7:0]         command_code;
        t_frame_kind        frame_kind;
    } t_frame_result;

    class frame_scoreboard;
        logic [7:0]    echo_code, status_code, motor_code;
        int unsigned   pos;
        bit            binary;
        logic [7:0]    len_byte, first_byte;
        int            tok_idx, tok_val;
        t_tok_flags    flags;
        int            pend[3];
        logic [2:0]    present;
        int            right_spd, left_spd, auto_val;
        t_frame_result expected_frames[$];
        int            errors;

        function new();
            echo_code   = ECHO_CODE_RST;
            status_code = STATUS_CODE_RST;
            motor_code  = MOTOR_CODE_RST;
            start_frame();
            pos       = 0;
            tok_idx   = 0;
            right_spd = 0;
            left_spd  = 0;
            auto_val  = 0;
            errors    = 0;
        endfunction

        function void write_cfg(t_cfg_index idx, logic [7:0] v);
            case (idx)
                CFG_ECHO_CODE:   echo_code = v;
                CFG_STATUS_CODE: status_code = v;
                CFG_MOTOR_CODE:  motor_code = v;
                default: ;
            endcase
        endfunction

        function void start_frame();
            pos        = 1;
            binary     = 1'b0;
            len_byte   = '0;
            first_byte = '0;
            tok_idx    = 1;
            tok_val    = 0;
            flags      = '0;
            pend       = '{0, 0, 0};
            present    = '0;
        endfunction

        function void finish_token();
            int cur;
            int v;
            if (!flags.in_tok) return;
            cur = tok_idx - 1;
            if (cur >= 2 && cur <= 4) begin
                if (flags.neg) v = -((tok_val > int'(TOKEN_SAT)) ? int'(TOKEN_SAT) : tok_val);
                else v = (tok_val > int'(TOKEN_MAX)) ? int'(TOKEN_MAX) : tok_val;
                pend[cur-2] = v;
            end
            flags = '0;
        endfunction

        function void accumulate(int d);
            tok_val = tok_val * 10 + d;
            if (tok_val > int'(TOKEN_SAT)) tok_val = int'(TOKEN_SAT);
        endfunction

        function void token_byte(logic [7:0] b);
            bit digit;
            digit = (b >= CH_ZERO && b <= CH_NINE);
            if (tok_idx == int'(TOKEN_ENDED)) return;
            if (b == CH_NUL) begin
                finish_token();
                tok_idx = int'(TOKEN_ENDED);
                return;
            end
            if (b == CH_SPACE) begin
                finish_token();
                return;
            end
            if (!flags.in_tok) begin
                flags        = '0;
                flags.in_tok = 1'b1;
                tok_val      = 0;
                if (tok_idx < int'(TOKEN_LAST)) tok_idx++;
                if (tok_idx >= 3 && tok_idx <= 5) present[tok_idx-3] = 1'b1;
            end
            if (flags.stop) return;
            if (!flags.seen) begin
                if (b >= CH_WS_LO && b <= CH_WS_HI) return;
                if (b == CH_PLUS) flags.seen = 1'b1;
                else if (b == CH_MINUS) begin
                    flags.seen = 1'b1;
                    flags.neg  = 1'b1;
                end else if (digit) begin
                    flags.seen = 1'b1;
                    accumulate(int'(b - CH_ZERO));
                end else flags.stop = 1'b1;
            end else if (digit) accumulate(int'(b - CH_ZERO));
            else flags.stop = 1'b1;
        endfunction

        function int motor_speed(int v);
            return (v * SPEED_NUM) / SPEED_DEN - SPEED_OFS;
        endfunction

        function void record_frame(t_frame_kind kind, logic [7:0] code);
            t_frame_result r;
            r.zero_pad     = '0;
            r.frame_kind   = kind;
            r.command_code = code;
            r.frame_length = pos[6:0];
            r.speed_right  = right_spd[15:0];
            r.speed_left   = left_spd[15:0];
            r.auto_mode    = auto_val[15:0];
            expected_frames.push_back(r);
        endfunction

        // one accepted byte through the parser state
        function void note_rx_byte(logic [7:0] b);
            t_frame_kind kind;
            logic [7:0]  code;
            if (pos == 0) begin
                if (b == CH_OPEN) start_frame();
                return;
            end
            if (pos == 1) begin
                if (b == CH_TEXT || b == CH_BINARY) begin
                    binary = (b == CH_BINARY);
                    pos    = 2;
                end else pos = 0;
                return;
            end
            if (pos == 2) begin
                pos = (b == CH_SPACE) ? 3 : 0;
                return;
            end
            if (!binary && b == CH_CLOSE) begin
                if (pos == 3) begin
                    kind = KIND_UNKNOWN;
                    code = '0;
                end else begin
                    code = first_byte;
                    if (code == echo_code) kind = KIND_ECHO;
                    else if (code == status_code) kind = KIND_STATUS;
                    else if (code == motor_code) begin
                        kind = KIND_MOTOR;
                        finish_token();
                        if (present[0]) right_spd = motor_speed(pend[0]);
                        if (present[1]) left_spd = motor_speed(pend[1]);
                        if (present[2]) auto_val = pend[2];
                    end else kind = KIND_UNKNOWN;
                end
                record_frame(kind, code);
                pos = 0;
                return;
            end
            if (binary && pos >= 4 && len_byte == pos) begin
                record_frame(KIND_BINARY, first_byte);
                pos = 0;
                return;
            end
            if (pos >= BUF_BYTES) begin
                pos = 0;
                if (b == CH_OPEN) start_frame();
                return;
            end
            if (pos == 3) begin
                first_byte = b;
                len_byte   = b;
            end
            if (!binary) token_byte(b);
            pos++;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_frame_result(logic [OUT_TDATA_W-1:0] d);
            t_frame_result      got, want;
            logic signed [16:0] got_f[7];
            logic signed [16:0] want_f[7];
            string names[7] = '{"frame_kind", "command_code", "frame_length", "speed_right",
                                "speed_left", "auto_flag", "padding"};
            got = t_frame_result'(d);
            if (expected_frames.size() == 0) begin
                report($sformatf("frame result %h with none expected", d));
                return;
            end
            want = expected_frames.pop_front();
            got_f  = '{got.frame_kind, got.command_code, got.frame_length, got.speed_right,
                       got.speed_left, got.auto_mode, got.zero_pad};
            want_f = '{want.frame_kind, want.command_code, want.frame_length, want.speed_right,
                       want.speed_left, want.auto_mode, want.zero_pad};
            for (int i = 0; i < 7; i++) begin
                if (got_f[i] !== want_f[i])
                    report($sformatf("%s got %0d expected %0d", names[i], got_f[i], want_f[i]));
            end
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_data   = '0;
    logic       res_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    t_cfg_index cfg_index = CFG_ECHO_CODE;
    logic [7:0] cfg_data  = '0;

    wire                   rx_ready;
    wire                   res_valid;
    wire [OUT_TDATA_W-1:0] res_data;
    wire                   cfg_ready;

    bit          idle_on  = 1'b1;
    bit          rx_gaps  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned rx_count = 0;
    int unsigned cycles   = 0;

    frame_scoreboard tracker;

    serial_command_frame_parser_top #(
        .BUFFER_SIZE(BUF_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (rx_valid),
        .o_s_tready  (rx_ready),
        .i_s_tdata   (rx_data),
        .o_m_tvalid  (res_valid),
        .i_m_tready  (res_ready),
        .o_m_tdata   (res_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && rx_gaps && $urandom_range(0, 5) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX)) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge clk); while (!rx_ready);
        tracker.note_rx_byte(b);
        rx_count++;
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_text_frame(input logic [7:0] code, input int nbody,
                                   input logic [7:0] last_b);
        logic [7:0] b;
        send_str("<@ ");
        send_byte(code);
        repeat (nbody) begin
            b = 8'($urandom_range(0, 255));
            send_byte((b == CH_CLOSE) ? FILL_BYTE : b);
        end
        send_byte(last_b);
    endtask

    task automatic send_binary_frame(input logic [7:0] len_b, input logic [7:0] last_b);
        send_str("<! ");
        send_byte(len_b);
        repeat ((len_b >= 4 && len_b <= BUF_BYTES) ? len_b - 4 : BUF_BYTES - 4)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(last_b);
    endtask

    // brings the parser back outside a frame
    task automatic close_frame();
        while (tracker.pos != 0)
            send_byte((tracker.binary && tracker.pos >= 3) ? FILL_BYTE : CH_CLOSE);
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (tracker.expected_frames.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_cfg(idx, v);
        @(negedge clk);
    endtask

    task automatic set_codes(input logic [7:0] e, input logic [7:0] s, input logic [7:0] m);
        write_reg(CFG_ECHO_CODE, e);
        write_reg(CFG_STATUS_CODE, s);
        write_reg(CFG_MOTOR_CODE, m);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        logic [7:0]  code;
        logic [7:0]  len_b;
        pick    = $urandom_range(0, 99);
        rx_gaps = ($urandom_range(0, 3) != 0);
        if (pick < 30) begin
            send_str("<@ ");
            send_byte(tracker.motor_code);
            repeat ($urandom_range(0, 5)) begin
                repeat ($urandom_range(1, 2)) send_byte(CH_SPACE);
                if ($urandom_range(0, 4) == 0)
                    send_byte(8'($urandom_range(CH_WS_LO, CH_WS_HI)));
                case ($urandom_range(0, 3))
                    0: send_byte(CH_PLUS);
                    1: send_byte(CH_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
                if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 24) == 0) send_byte(CH_NUL);
            end
            send_byte(CH_CLOSE);
        end else if (pick < 55) begin
            case ($urandom_range(0, 3))
                0: code = tracker.echo_code;
                1: code = tracker.status_code;
                2: code = tracker.motor_code;
                default: code = 8'($urandom_range(0, 255));
            endcase
            send_text_frame(code,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(58, 64)
                                                        : $urandom_range(0, 10),
                            ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                         : CH_CLOSE);
        end else if (pick < 75) begin
            case ($urandom_range(0, 9))
                0: len_b = 8'($urandom_range(0, 255));
                1: len_b = 8'(BUF_BYTES);
                default: len_b = 8'($urandom_range(4, 24));
            endcase
            send_binary_frame(len_b, 8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(CH_OPEN);
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
            else begin
                send_byte(($urandom_range(0, 1) == 0) ? CH_TEXT : CH_BINARY);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX)) @(negedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) tracker.check_frame_result(res_data);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned phase_start;
        tracker = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_str("zz>");
        send_str("<@ >");
        send_str("<@ Ehello>");
        send_str("<@ S>");
        send_str("<@ Q1>");
        send_str("<@ M 1023 0 -7>");
        send_str("<@ M 99999 -99999 +32767>");
        send_str("<@ M -32768 32767 -32768>");
        send_str("<@ M ");
        send_byte(CH_WS_LO);
        send_byte(CH_WS_HI);
        send_str("-12 4x5 ++3 - >");
        send_str("<@ M 5");
        send_byte(CH_NUL);
        send_str(" 7 9>");
        send_str("<@ M 10>");
        send_str("<x<@x<@ E>");
        send_binary_frame(8'd4, 8'hAA);
        send_binary_frame(8'(BUF_BYTES), 8'hFF);
        send_binary_frame(8'(BUF_BYTES + 1), CH_OPEN);
        send_str("@ S>");
        send_binary_frame(8'd0, FILL_BYTE);
        send_binary_frame(8'hFF, 8'h00);
        send_text_frame(ECHO_CODE_RST, BUF_BYTES - 4, CH_CLOSE);
        send_text_frame(ECHO_CODE_RST, BUF_BYTES - 4, 8'h62);
        send_text_frame(STATUS_CODE_RST, BUF_BYTES - 4, CH_OPEN);
        send_str("@ S>");

        for (int p = 1; p <= 5; p++) begin
            close_frame();
            wait_idle();
            case (p)
                1: set_codes(8'h00, 8'hFF, CH_SPACE);
                3: set_codes(8'hFF, 8'h00, MOTOR_CODE_RST);
                5: set_codes(ECHO_CODE_RST, STATUS_CODE_RST, MOTOR_CODE_RST);
                default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
            endcase
            idle_on = (p != 5);
            phase_start = rx_count;
            if (p == 2) begin
                hold_req = 1'b1;
                // a waiting result stalls the next frame during the hold-off
                send_str("<@ S>");
                send_str("<@ S>");
            end
            while (rx_count - phase_start < PHASE_BYTES) send_random_frame();
        end

        close_frame();
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/scfp_pkg.sv
design/serial_command_frame_parser_top.sv
design/scfp_checker.sv
sim/serial_command_frame_parser_top_tb.sv
